>>> sv/kps_pkg.sv
`timescale 1ns / 1ps
package kps_pkg;

  localparam int TICK_W  = 24;
  localparam int POS_W   = 32;
  localparam int QTICK_W = 32;
  localparam int FRAC_W  = 24;   // interpolation weight, unsigned q0.24
  localparam int CFG_W   = 7;

  typedef struct packed {
    logic [TICK_W-1:0]       tick;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } key_t;

endpackage

>>> sv/kps_in_if.sv
`timescale 1ns / 1ps
interface kps_in_if import kps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [5:0]               key_index;
  logic [TICK_W-1:0]        key_tick;
  logic signed [POS_W-1:0]  key_x;
  logic signed [POS_W-1:0]  key_y;
  logic signed [POS_W-1:0]  key_z;
  logic [QTICK_W-1:0]       query_tick;

  modport source (output valid, mode, key_index, key_tick, key_x, key_y, key_z, query_tick,
                  input ready);
  modport sink (input valid, mode, key_index, key_tick, key_x, key_y, key_z, query_tick,
                output ready);
endinterface

>>> sv/kps_out_if.sv
`timescale 1ns / 1ps
interface kps_out_if import kps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;

  modport source (output valid, found, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, found, pos_x, pos_y, pos_z, output ready);
endinterface

>>> sv/keyframe_position_sampler_core.sv
`timescale 1ns / 1ps
// load request: written to the key memory at the accepting edge when key_index < MAX_KEYS, no response
// query request: the response follows a memory scan of n keys (n <= key_count),
//   one key per cycle, and the 24-step serial divider;
//   the divide is skipped on a flat span or clamped weight, and both are skipped for an empty table
// one request in flight at a time; a finished response waits in the output register
// reset (rst_n, synchronous): key_count = 0, control idle; key memory is not cleared
module keyframe_position_sampler_core import kps_pkg::*; #(
  parameter int MAX_KEYS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  kps_in_if.sink           in_ch,
  kps_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // key memory: one entry holds tick and position, registered read
  key_t mem [MAX_KEYS];
  key_t rd_data_r;
  logic [AW-1:0] rd_addr;

  logic [2:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   key_count_r;
  logic [NW-1:0]      n_r, n_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [QTICK_W-1:0] q_r, q_nxt;
  key_t               start_r, start_nxt;
  key_t               end_r, end_nxt;
  logic [31:0]        num_r, num_nxt;   // remainder during the divide
  logic [31:0]        den_r, den_nxt;
  logic [FRAC_W-1:0]  t_r, t_nxt;
  logic [4:0]         step_r, step_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic               phase_r, phase_nxt;  // 0: multiply, 1: add
  logic signed [57:0] prod_r, prod_nxt;
  logic signed [POS_W-1:0] res_x_r, res_y_r, res_z_r;
  logic signed [POS_W-1:0] res_x_nxt, res_y_nxt, res_z_nxt;
  logic               found_r, found_nxt;

  logic out_valid_r;
  logic signed [POS_W-1:0] out_x_r, out_y_r, out_z_r;
  logic out_found_r;

  logic in_fire, load_fire, query_fire;
  logic [NW-1:0] n_sat, kc_ext;
  logic [31:0]   key_scaled;
  logic [24:0]   tick_diff;
  logic [31:0]   num_init;
  logic [32:0]   rem2;
  logic signed [POS_W-1:0] a_sel, b_sel;
  logic signed [32:0] delta;
  logic signed [57:0] prod_sh;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign load_fire   = in_fire & ~in_ch.mode;
  assign query_fire  = in_fire & in_ch.mode;

  assign kc_ext = NW'(key_count_r);
  assign n_sat  = (kc_ext > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : kc_ext;

  // read slot 0 while idle, then the slot after the one being compared
  assign rd_addr = (state_r == S_IDLE) ? '0 : cmp_idx_r + AW'(1);

  always_ff @(posedge clk) begin
    if (load_fire && (11'(in_ch.key_index) < 11'(MAX_KEYS))) begin
      mem[AW'(in_ch.key_index)] <= '{in_ch.key_tick, in_ch.key_x, in_ch.key_y, in_ch.key_z};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (cfg_we) begin
      key_count_r <= cfg_wdata;
    end
  end

  assign key_scaled = {rd_data_r.tick, 8'h00};
  assign tick_diff  = {1'b0, end_r.tick} - {1'b0, start_r.tick};
  assign num_init   = q_r - {start_r.tick, 8'h00};
  assign rem2       = {num_r, 1'b0};

  always_comb begin
    case (axis_r)
      2'd0:    begin a_sel = start_r.x; b_sel = end_r.x; end
      2'd1:    begin a_sel = start_r.y; b_sel = end_r.y; end
      default: begin a_sel = start_r.z; b_sel = end_r.z; end
    endcase
  end

  assign delta   = $signed({b_sel[POS_W-1], b_sel}) - $signed({a_sel[POS_W-1], a_sel});
  assign prod_sh = prod_r >>> FRAC_W;   // arithmetic shift floors toward minus infinity

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    cmp_idx_nxt = cmp_idx_r;
    q_nxt       = q_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    t_nxt       = t_r;
    step_nxt    = step_r;
    axis_nxt    = axis_r;
    phase_nxt   = phase_r;
    prod_nxt    = prod_r;
    res_x_nxt   = res_x_r;
    res_y_nxt   = res_y_r;
    res_z_nxt   = res_z_r;
    found_nxt   = found_r;
    case (state_r)
      S_IDLE: begin
        if (query_fire) begin
          n_nxt       = n_sat;
          q_nxt       = in_ch.query_tick;
          cmp_idx_nxt = '0;
          start_nxt   = '0;   // implicit key at tick 0, position zero
          res_x_nxt   = '0;
          res_y_nxt   = '0;
          res_z_nxt   = '0;
          if (n_sat == '0) begin
            found_nxt = 1'b0;
            state_nxt = S_FIN;
          end else begin
            found_nxt = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // last compared entry is the end key whether or not the scan breaks
        end_nxt = rd_data_r;
        if (key_scaled <= q_r) begin
          start_nxt = rd_data_r;
          if (NW'(cmp_idx_r) == n_r - NW'(1)) begin
            state_nxt = S_PREP;
          end else begin
            cmp_idx_nxt = cmp_idx_r + AW'(1);
          end
        end else begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        den_nxt  = {tick_diff[23:0], 8'h00};
        num_nxt  = num_init;
        step_nxt = '0;
        axis_nxt = '0;
        phase_nxt = 1'b0;
        if (tick_diff[24] || (tick_diff == '0)) begin
          t_nxt     = '0;
          state_nxt = S_MUL;
        end else if (num_init >= {tick_diff[23:0], 8'h00}) begin
          t_nxt     = '1;
          state_nxt = S_MUL;
        end else begin
          t_nxt     = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem2 >= {1'b0, den_r}) begin
          num_nxt = 32'(rem2 - {1'b0, den_r});
          t_nxt   = {t_r[FRAC_W-2:0], 1'b1};
        end else begin
          num_nxt = rem2[31:0];
          t_nxt   = {t_r[FRAC_W-2:0], 1'b0};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(FRAC_W - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (!phase_r) begin
          prod_nxt  = delta * $signed({1'b0, t_r});
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          case (axis_r)
            2'd0:    res_x_nxt = a_sel + prod_sh[POS_W-1:0];
            2'd1:    res_y_nxt = a_sel + prod_sh[POS_W-1:0];
            default: res_z_nxt = a_sel + prod_sh[POS_W-1:0];
          endcase
          if (axis_r == 2'd2) begin
            state_nxt = S_FIN;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r       <= n_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    q_r       <= q_nxt;
    start_r   <= start_nxt;
    end_r     <= end_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    t_r       <= t_nxt;
    step_r    <= step_nxt;
    axis_r    <= axis_nxt;
    phase_r   <= phase_nxt;
    prod_r    <= prod_nxt;
    res_x_r   <= res_x_nxt;
    res_y_r   <= res_y_nxt;
    res_z_r   <= res_z_nxt;
    found_r   <= found_nxt;
  end

  // output register: freed by the sink, refilled when a query finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FIN) && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if ((state_r == S_FIN) && (!out_valid_r || out_ch.ready)) begin
      out_found_r <= found_r;
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_z_r     <= res_z_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.found = out_found_r;
  assign out_ch.pos_x = out_x_r;
  assign out_ch.pos_y = out_y_r;
  assign out_ch.pos_z = out_z_r;

endmodule

>>> sv/kps_checker.sv
`timescale 1ns / 1ps
module kps_checker import kps_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_mode,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_found,
  input logic [POS_W-1:0] out_pos_x,
  input logic [POS_W-1:0] out_pos_y,
  input logic [POS_W-1:0] out_pos_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_pos_x == '0) && (out_pos_y == '0) && (out_pos_z == '0))
    else $error("empty table response not zero");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("request taken while query in flight");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("response one cycle after request");

endmodule

bind keyframe_position_sampler_core kps_checker u_kps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_found (out_ch.found),
  .out_pos_x (out_ch.pos_x),
  .out_pos_y (out_ch.pos_y),
  .out_pos_z (out_ch.pos_z)
);
